### hdl/bitmap_frame_allocator_macros.svh
// assertion helpers used by the allocator top file
`ifndef BITMAP_FRAME_ALLOCATOR_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define BFA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BFA_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/bfa_pkg.sv
package bfa_pkg;

    // frame capacity default and map word geometry
    localparam int MAX_FRAMES_DEF = 1024;
    localparam int WORD_BITS      = 32;
    localparam int WORD_AW        = 5;

    // fixed field widths
    localparam int REQ_W    = 2;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 11;
    localparam int CFG_W    = 11;

    // reset value of the frame count register
    localparam int RESET_FRAMES = 1024;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESERVE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OOM    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BADIDX = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_DOUBLE = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [INDEX_W-1:0] frame_index;
    } bfa_in_t;

    typedef struct packed {
        logic [INDEX_W-1:0]  frame_number;
        logic [STATUS_W-1:0] status;
        logic [TOTAL_W-1:0]  free_frames_left;
    } bfa_out_t;

    // control into the word unit
    typedef struct packed {
        logic               scan;
        logic               limit_en;
        logic [WORD_AW-1:0] limit_bit;
        logic [WORD_AW-1:0] bit_sel;
        logic               set_val;
    } bfa_unit_ctrl_t;

    // status out of the word unit
    typedef struct packed {
        logic               hit;
        logic [WORD_AW-1:0] pos;
    } bfa_unit_res_t;

endpackage

### hdl/bfa_ram.sv
module bfa_ram
    import bfa_pkg::*;
#(
    parameter int WIDTH = WORD_BITS,
    parameter int DEPTH = MAX_FRAMES_DEF / WORD_BITS,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/bfa_word_unit.sv
module bfa_word_unit
    import bfa_pkg::*;
(
    input  logic [WORD_BITS-1:0] word,
    input  bfa_unit_ctrl_t       ctrl,
    output bfa_unit_res_t        res,
    output logic [WORD_BITS-1:0] word_upd
);

    logic [WORD_BITS-1:0] masked;
    logic [WORD_AW-1:0]   low_pos;

    // drop bits at or above the frame count in the last word
    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            masked[i] = word[i] && (!ctrl.limit_en || (WORD_AW'(i) <= ctrl.limit_bit));
        end
    end

    // lowest set bit of the masked word
    always_comb begin
        low_pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (masked[i]) begin
                low_pos = WORD_AW'(i);
            end
        end
    end

    // scan picks the first free bit, otherwise test the selected bit
    always_comb begin
        if (ctrl.scan) begin
            res.hit = |masked;
            res.pos = low_pos;
        end else begin
            res.hit = word[ctrl.bit_sel];
            res.pos = ctrl.bit_sel;
        end
    end

    // word with the chosen bit forced
    always_comb begin
        word_upd          = word;
        word_upd[res.pos] = ctrl.set_val;
    end

endmodule

### hdl/bitmap_frame_allocator.sv
// channel   | ports                       | transfer
// ----------+-----------------------------+-------------------------------------
// request   | s_valid s_ready s_data      | req_type, frame_index
// result    | m_valid m_ready m_data      | frame_number, status, free_frames_left
// config    | cfg_wr_en cfg_wr_data       | num_frames, no wait, no read-back
//
// allocate reads map words one after another, up to MAX_FRAMES/32 of them (32 by default):
// the map RAM delivers one 32-bit word per cycle to the shared word unit.
// free and reserve pass through S_EVAL; a bad index or unknown request goes straight to S_FIN.
// after reset and after each num_frames write the map is set to all free by a
// pass over every map word; requests are held off meanwhile.
// a finished result waits in the output register; a new request is taken while it waits.
`include "bitmap_frame_allocator_macros.svh"

module bitmap_frame_allocator
    import bfa_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  bfa_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output bfa_out_t         m_data,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    localparam int WORDS  = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam logic [CNT_W-1:0] RESET_EFF =
        CNT_W'((RESET_FRAMES > MAX_FRAMES) ? MAX_FRAMES : RESET_FRAMES);
    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(WORDS - 1);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EVAL  = 4'b0100,
        S_FIN   = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     free_total_reg, free_total_next;
    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0]    scan_addr_reg, scan_addr_next;
    logic [REQ_W-1:0]     req_reg, req_next;
    logic [WORD_AW-1:0]   bit_reg, bit_next;
    logic [INDEX_W-1:0]   res_frame_reg, res_frame_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic                 m_valid_reg, m_valid_next;
    bfa_out_t             m_data_reg, m_data_next;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] ram_wdata_upd;

    bfa_unit_ctrl_t       unit_ctrl;
    bfa_unit_res_t        unit_res;
    logic [WORD_BITS-1:0] unit_word;

    logic [CNT_W-1:0]     cfg_eff;
    logic [31:0]          cnt_m1;
    logic [ADDR_W-1:0]    last_addr;
    logic                 idx_bad;
    logic [31:0]          frame_full;
    logic                 out_free;

    // clamp a written frame count to the capacity
    always_comb begin
        if (32'(cfg_wr_data) > 32'(MAX_FRAMES)) begin
            cfg_eff = CNT_W'(MAX_FRAMES);
        end else begin
            cfg_eff = CNT_W'(cfg_wr_data);
        end
    end

    // last map word and last bit in it below the frame count
    assign cnt_m1    = 32'(count_reg) - 32'd1;
    assign last_addr = ADDR_W'(cnt_m1 >> WORD_AW);
    assign idx_bad   = 32'(s_data.frame_index) >= 32'(count_reg);
    assign out_free  = !m_valid_reg || m_ready;

    // frame number of the bit found in the current word
    assign frame_full = (32'(scan_addr_reg) << WORD_AW) | 32'(unit_res.pos);

    // shared word unit on the map read data
    assign unit_word          = ram_rdata;
    assign unit_ctrl.scan     = (req_reg == REQ_ALLOC);
    assign unit_ctrl.limit_en = (scan_addr_reg == last_addr);
    assign unit_ctrl.limit_bit = cnt_m1[WORD_AW-1:0];
    assign unit_ctrl.bit_sel  = bit_reg;
    assign unit_ctrl.set_val  = (req_reg == REQ_FREE);

    bfa_word_unit u_word_unit (
        .word     (unit_word),
        .ctrl     (unit_ctrl),
        .res      (unit_res),
        .word_upd (ram_wdata_upd)
    );

    // free map, one bit per frame, 32 frames to a word
    bfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        free_total_next = free_total_reg;
        clr_addr_next   = clr_addr_reg;
        scan_addr_next  = scan_addr_reg;
        req_next        = req_reg;
        bit_next        = bit_reg;
        res_frame_next  = res_frame_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = scan_addr_reg;
        ram_wdata       = ram_wdata_upd;
        ram_raddr       = scan_addr_reg + 1'b1;

        unique case (state_reg)
            S_CLEAR: begin
                // set one map word to all free per cycle
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '1;
                if (clr_addr_reg == LAST_WORD) begin
                    state_next = S_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            S_IDLE: begin
                // take a request and start the first map read
                ram_raddr = (s_data.req_type == REQ_ALLOC) ? '0
                          : ADDR_W'(s_data.frame_index >> WORD_AW);
                if (s_valid) begin
                    req_next        = s_data.req_type;
                    bit_next        = s_data.frame_index[WORD_AW-1:0];
                    scan_addr_next  = ram_raddr;
                    res_frame_next  = '0;
                    res_status_next = STAT_OK;
                    state_next      = S_FIN;
                    case (s_data.req_type) inside
                        REQ_ALLOC: begin
                            if (count_reg == '0) begin
                                res_status_next = STAT_OOM;
                            end else begin
                                state_next = S_EVAL;
                            end
                        end
                        REQ_FREE, REQ_RESERVE: begin
                            if (idx_bad) begin
                                res_status_next = STAT_BADIDX;
                            end else begin
                                state_next = S_EVAL;
                            end
                        end
                        default: begin
                            res_status_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_EVAL: begin
                case (req_reg)
                    REQ_ALLOC: begin
                        // first free frame, else move on to the next word
                        if (unit_res.hit) begin
                            ram_we          = 1'b1;
                            free_total_next = free_total_reg - 1'b1;
                            res_frame_next  = frame_full[INDEX_W-1:0];
                            state_next      = S_FIN;
                        end else if (unit_ctrl.limit_en) begin
                            res_status_next = STAT_OOM;
                            state_next      = S_FIN;
                        end else begin
                            scan_addr_next = scan_addr_reg + 1'b1;
                        end
                    end
                    REQ_FREE: begin
                        // a set bit is already free
                        if (unit_res.hit) begin
                            res_status_next = STAT_DOUBLE;
                        end else begin
                            ram_we          = 1'b1;
                            free_total_next = free_total_reg + 1'b1;
                        end
                        state_next = S_FIN;
                    end
                    default: begin
                        // reserve: only a free frame changes
                        if (unit_res.hit) begin
                            ram_we          = 1'b1;
                            free_total_next = free_total_reg - 1'b1;
                        end
                        state_next = S_FIN;
                    end
                endcase
            end
            S_FIN: begin
                // hand the result to the output register once it is free
                if (out_free) begin
                    m_valid_next                 = 1'b1;
                    m_data_next.frame_number     = res_frame_reg;
                    m_data_next.status           = res_status_reg;
                    m_data_next.free_frames_left = TOTAL_W'(32'(free_total_reg));
                    state_next                   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase

        // frame count write restarts the map
        if (cfg_wr_en) begin
            count_next      = cfg_eff;
            free_total_next = cfg_eff;
            clr_addr_next   = '0;
            state_next      = S_CLEAR;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            count_reg      <= RESET_EFF;
            free_total_reg <= RESET_EFF;
            clr_addr_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            free_total_reg <= free_total_next;
            clr_addr_reg   <= clr_addr_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        scan_addr_reg  <= scan_addr_next;
        req_reg        <= req_next;
        bit_reg        <= bit_next;
        res_frame_reg  <= res_frame_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // free count never exceeds the managed count
    `BFA_ASSERT_IMP(a_total_bound, aclk, aresetn, 1'b1,
        free_total_reg <= count_reg, "free count above frame count")
    // an allocate scan never passes the last managed word
    `BFA_ASSERT_IMP(a_scan_bound, aclk, aresetn,
        (state_reg == S_EVAL) && (req_reg == REQ_ALLOC),
        scan_addr_reg <= last_addr, "scan beyond last word")
    // map writes happen only while clearing or updating
    `BFA_ASSERT_IMP(a_write_state, aclk, aresetn, ram_we,
        (state_reg == S_CLEAR) || (state_reg == S_EVAL), "map written outside clear or update")
    // one request moves the free count by at most one
    `BFA_ASSERT_NXT(a_total_step, aclk, aresetn, (state_reg == S_EVAL) && !cfg_wr_en,
        (free_total_reg == $past(free_total_reg))
        || (free_total_reg == $past(free_total_reg) + 1'b1)
        || (free_total_reg == $past(free_total_reg) - 1'b1),
        "free count jumped")

endmodule

### tb/tb_bitmap_frame_allocator.sv
module tb_bitmap_frame_allocator;
    import bfa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // request code the block ignores
    localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_ITEMS  = 175;
    localparam int PHASE_COUNT  = 10;
    localparam int ROW_COUNT    = 28;

    // one row of the directed table: a frame count write or a request
    typedef struct packed {
        logic             cfg;
        logic [CFG_W-1:0] cfg_val;
        bfa_in_t          rq;
        logic             typed;
        bfa_out_t         want;
    } stim_row_t;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    bfa_in_t          s_data      = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    bfa_out_t         m_data;
    logic             cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;

    // shadow copy of the allocator state
    logic     shadow_free [MAX_FRAMES_DEF];
    int       shadow_left;
    int       shadow_frames;

    bfa_out_t  expected_grants [$];
    int        errors = 0;
    int        cycles = 0;
    stim_row_t stim_rows [ROW_COUNT];

    bitmap_frame_allocator u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // effective frame count, clamped to capacity
    function automatic int managed_frames();
        return (shadow_frames > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : shadow_frames;
    endfunction

    // mark every frame free under a new frame count
    function automatic void clear_shadow(input int frames);
        int i;
        shadow_frames = frames;
        for (i = 0; i < MAX_FRAMES_DEF; i++) begin
            shadow_free[i] = 1'b1;
        end
        shadow_left = managed_frames();
    endfunction

    // expected grant for one request, updating the shadow state
    function automatic bfa_out_t predict_grant(input bfa_in_t rq);
        bfa_out_t r;
        int       lim;
        int       i;
        int       idx;
        logic     found;
        lim            = managed_frames();
        idx            = int'(rq.frame_index);
        r.frame_number = '0;
        r.status       = STAT_OK;
        found          = 1'b0;
        case (rq.req_type)
            REQ_ALLOC: begin
                r.status = STAT_OOM;
                for (i = 0; i < lim && !found; i++) begin
                    if (shadow_free[i]) begin
                        shadow_free[i] = 1'b0;
                        shadow_left--;
                        r.frame_number = INDEX_W'(i);
                        r.status       = STAT_OK;
                        found          = 1'b1;
                    end
                end
            end
            REQ_FREE: begin
                if (idx >= lim) begin
                    r.status = STAT_BADIDX;
                end else if (shadow_free[idx]) begin
                    r.status = STAT_DOUBLE;
                end else begin
                    shadow_free[idx] = 1'b1;
                    shadow_left++;
                end
            end
            REQ_RESERVE: begin
                if (idx >= lim) begin
                    r.status = STAT_BADIDX;
                end else if (shadow_free[idx]) begin
                    shadow_free[idx] = 1'b0;
                    shadow_left--;
                end
            end
            default: begin
            end
        endcase
        r.free_frames_left = TOTAL_W'(shadow_left);
        return r;
    endfunction

    // a used frame in range, or -1 when none is used
    function automatic int pick_used_frame();
        int lim;
        int start;
        int k;
        int i;
        lim = managed_frames();
        if (lim == 0) begin
            return -1;
        end
        start = $urandom_range(0, lim - 1);
        for (k = 0; k < lim; k++) begin
            i = (start + k) % lim;
            if (!shadow_free[i]) begin
                return i;
            end
        end
        return -1;
    endfunction

    // mostly well-formed traffic, some bad indices and unknown codes
    function automatic bfa_in_t next_request(input int alloc_pct);
        bfa_in_t rq;
        int      lim;
        int      roll;
        int      f;
        lim            = managed_frames();
        roll           = $urandom_range(0, 99);
        rq.req_type    = REQ_ALLOC;
        rq.frame_index = INDEX_W'($urandom);
        if (roll < alloc_pct) begin
            rq.req_type = REQ_ALLOC;
        end else if (roll < 75) begin
            f = pick_used_frame();
            if (f >= 0) begin
                rq.req_type    = REQ_FREE;
                rq.frame_index = INDEX_W'(f);
            end
        end else if (roll < 85 && lim > 0) begin
            rq.req_type    = REQ_RESERVE;
            rq.frame_index = INDEX_W'($urandom_range(0, lim - 1));
        end else begin
            case ($urandom_range(0, 2))
                0: begin
                    rq.req_type = REQ_W'($urandom_range(0, 3));
                end
                1: begin
                    rq.req_type = REQ_FREE;
                    if (lim > 0) begin
                        rq.frame_index = INDEX_W'($urandom_range(0, lim - 1));
                    end
                end
                default: begin
                    rq.req_type = ($urandom_range(0, 1) == 0) ? REQ_FREE : REQ_RESERVE;
                    if (lim < MAX_FRAMES_DEF) begin
                        rq.frame_index = INDEX_W'($urandom_range(lim, MAX_FRAMES_DEF - 1));
                    end
                end
            endcase
        end
        return rq;
    endfunction

    // present one request and hold it until the transfer
    task automatic send_request(input bfa_in_t rq, input logic typed, input bfa_out_t want);
        bfa_out_t pred;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= rq;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        pred = predict_grant(rq);
        expected_grants.push_back(typed ? want : pred);
    endtask

    // sender gap: s_valid dropped for a span given by n
    task automatic hold_sender(input int n);
        if (n > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    // stop sending until every grant is back
    task automatic drain_grants();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_grants.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // frame count write while the block is idle
    task automatic write_frame_count(input logic [CFG_W-1:0] val);
        drain_grants();
        repeat (4) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        clear_shadow(int'(val));
    endtask

    task automatic check_field(input string fname, input logic [10:0] want,
                               input logic [10:0] got);
        if (got !== want) begin
            $display("%0t tb: mismatch on %s expected %0d actual %0d", $time, fname, want, got);
            errors++;
        end
    endtask

    // result checking against the oldest expectation
    always @(posedge aclk) begin
        bfa_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_grants.size() == 0) begin
                $display("%0t tb: unexpected result frame %0d status %0d left %0d", $time,
                         m_data.frame_number, m_data.status, m_data.free_frames_left);
                errors++;
            end else begin
                want = expected_grants.pop_front();
                check_field("frame_number", 11'(want.frame_number), 11'(m_data.frame_number));
                check_field("status", 11'(want.status), 11'(m_data.status));
                check_field("free_frames_left", want.free_frames_left,
                            m_data.free_frames_left);
            end
        end
    end

    // receiver stalls, switching between patterns
    always @(negedge aclk) begin
        static int rs_mode = 0;
        static int rs_left = 0;
        static int rs_tick = 0;
        if (rs_left == 0) begin
            rs_mode = $urandom_range(0, 3);
            rs_left = $urandom_range(20, 300);
        end else begin
            rs_left = rs_left - 1;
        end
        rs_tick = rs_tick + 1;
        case (rs_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 3) != 0);
            2:       m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= ((rs_tick % 7) < 3);
        endcase
    end

    initial begin
        int         r;
        int         p;
        int         n;
        int         burst;
        int         alloc_pct;
        int         phase_cfg [PHASE_COUNT];
        stim_row_t  row;

        // directed table: extremes, every request code, bad index, double free, clamp
        stim_rows = '{
            '{1'b0, 11'd0,    '{REQ_ALLOC,   10'd0},    1'b1, '{10'd0, STAT_OK,     11'd1023}},
            '{1'b0, 11'd0,    '{REQ_FREE,    10'd1023}, 1'b1, '{10'd0, STAT_DOUBLE, 11'd1023}},
            '{1'b0, 11'd0,    '{REQ_RESERVE, 10'd1023}, 1'b1, '{10'd0, STAT_OK,     11'd1022}},
            '{1'b0, 11'd0,    '{REQ_RESERVE, 10'd1023}, 1'b1, '{10'd0, STAT_OK,     11'd1022}},
            '{1'b0, 11'd0,    '{REQ_ALLOC,   10'd0},    1'b1, '{10'd1, STAT_OK,     11'd1021}},
            '{1'b0, 11'd0,    '{REQ_FREE,    10'd0},    1'b1, '{10'd0, STAT_OK,     11'd1022}},
            '{1'b0, 11'd0,    '{REQ_ALLOC,   10'd1023}, 1'b0, '{10'd0, STAT_OK,     11'd0}},
            '{1'b0, 11'd0,    '{REQ_NONE,    10'd1023}, 1'b0, '{10'd0, STAT_OK,     11'd0}},
            '{1'b1, 11'd0,    '{REQ_ALLOC,   10'd0},    1'b0, '{10'd0, STAT_OK,     11'd0}},
            '{1'b0, 11'd0,    '{REQ_ALLOC,   10'd0},    1'b1, '{10'd0, STAT_OOM,    11'd0}},
            '{1'b0, 11'd0,    '{REQ_FREE,    10'd0},    1'b1, '{10'd0, STAT_BADIDX, 11'd0}},
            '{1'b0, 11'd0,    '{REQ_RESERVE, 10'd1023}, 1'b1, '{10'd0, STAT_BADIDX, 11'd0}},
            '{1'b0, 11'd0,    '{REQ_NONE,    10'd0},    1'b1, '{10'd0, STAT_OK,     11'd0}},
            '{1'b1, 11'd1,    '{REQ_ALLOC,   10'd0},    1'b0, '{10'd0, STAT_OK,     11'd0}},
            '{1'b0, 11'd0,    '{REQ_ALLOC,   10'd0},    1'b1, '{10'd0, STAT_OK,     11'd0}},
            '{1'b0, 11'd0,    '{REQ_ALLOC,   10'd0},    1'b1, '{10'd0, STAT_OOM,    11'd0}},
            '{1'b0, 11'd0,    '{REQ_FREE,    10'd1},    1'b1, '{10'd0, STAT_BADIDX, 11'd0}},
            '{1'b0, 11'd0,    '{REQ_FREE,    10'd0},    1'b1, '{10'd0, STAT_OK,     11'd1}},
            '{1'b0, 11'd0,    '{REQ_FREE,    10'd0},    1'b1, '{10'd0, STAT_DOUBLE, 11'd1}},
            '{1'b0, 11'd0,    '{REQ_RESERVE, 10'd0},    1'b1, '{10'd0, STAT_OK,     11'd0}},
            '{1'b1, 11'd2047, '{REQ_ALLOC,   10'd0},    1'b0, '{10'd0, STAT_OK,     11'd0}},
            '{1'b0, 11'd0,    '{REQ_ALLOC,   10'd0},    1'b1, '{10'd0, STAT_OK,     11'd1023}},
            '{1'b0, 11'd0,    '{REQ_RESERVE, 10'd1023}, 1'b1, '{10'd0, STAT_OK,     11'd1022}},
            '{1'b0, 11'd0,    '{REQ_FREE,    10'd1023}, 1'b1, '{10'd0, STAT_OK,     11'd1023}},
            '{1'b0, 11'd0,    '{REQ_RESERVE, 10'd512},  1'b0, '{10'd0, STAT_OK,     11'd0}},
            '{1'b0, 11'd0,    '{REQ_ALLOC,   10'd0},    1'b0, '{10'd0, STAT_OK,     11'd0}},
            '{1'b1, 11'd1024, '{REQ_ALLOC,   10'd0},    1'b0, '{10'd0, STAT_OK,     11'd0}},
            '{1'b0, 11'd0,    '{REQ_FREE,    10'd1023}, 1'b1, '{10'd0, STAT_DOUBLE, 11'd1024}}
        };

        // frame count per random phase, extremes among them
        phase_cfg = '{1024, 64, 1, 17, 0, 2047, 33, 8, 2, 5};
        phase_cfg[7] = $urandom_range(2, 200);
        phase_cfg[8] = $urandom_range(2, 200);

        // synchronous reset
        clear_shadow(RESET_FRAMES);
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part
        for (r = 0; r < ROW_COUNT; r++) begin
            row = stim_rows[r];
            if (row.cfg) begin
                write_frame_count(row.cfg_val);
            end else begin
                send_request(row.rq, row.typed, row.want);
                hold_sender($urandom_range(0, 3));
            end
        end

        // random phases, traffic in bursts with gaps
        for (p = 0; p < PHASE_COUNT; p++) begin
            write_frame_count(CFG_W'(phase_cfg[p]));
            alloc_pct = $urandom_range(25, 65);
            n = 0;
            while (n < PHASE_ITEMS) begin
                if ($urandom_range(0, 39) == 0) begin
                    drain_grants();
                end
                burst = $urandom_range(1, 16);
                repeat (burst) begin
                    send_request(next_request(alloc_pct), 1'b0, '0);
                    n++;
                end
                hold_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10));
            end
        end

        // wait for the tail and let the block settle
        drain_grants();
        repeat (40) @(posedge aclk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### bitmap_frame_allocator.f
+incdir+hdl
hdl/bfa_pkg.sv
hdl/bfa_ram.sv
hdl/bfa_word_unit.sv
hdl/bitmap_frame_allocator.sv
tb/tb_bitmap_frame_allocator.sv
